### hw/rtl/calendar_to_seconds_macros.svh
// assertion macros shared by the calendar to seconds checker files
// no dependencies; the using module must have aclk and aresetn in scope
`ifndef CALENDAR_TO_SECONDS_MACROS_SVH
`define CALENDAR_TO_SECONDS_MACROS_SVH

// property checked on every clock edge outside reset
`define CTS_ASSERT(name, prop) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) prop) \
        else $error("%m: assertion failed");

// property that must also hold while reset is asserted
`define CTS_ASSERT_RST(name, prop) \
    name: assert property (@(posedge aclk) prop) \
        else $error("%m: reset assertion failed");

`endif

### hw/rtl/cts_pkg.sv
// shared constants and month table for the calendar to seconds block
// no dependencies
package cts_pkg;

    localparam int YEAR_W  = 7;
    localparam int MONTH_W = 4;
    localparam int DAY_W   = 5;
    localparam int HOUR_W  = 5;
    localparam int MIN_W   = 6;
    localparam int SEC_W   = 6;
    localparam int COUNT_W = 32;
    localparam int CENT_W  = 8;
    // day index: at most 127*365 + 32 + 335 + 31, fits 16 bits
    localparam int DAYS_W  = 16;
    // time of day: at most 31*3600 + 63*60 + 63, fits 17 bits
    localparam int TOD_W   = 17;
    localparam int DBM_W   = 9;

    localparam logic [COUNT_W-1:0] SECS_PER_DAY     = 32'd86400;
    localparam logic [COUNT_W-1:0] SECS_PER_CENTURY = 32'd3155692521;
    localparam logic [TOD_W-1:0]   SECS_PER_HOUR    = 17'd3600;
    localparam logic [TOD_W-1:0]   SECS_PER_MINUTE  = 17'd60;
    localparam logic [DAYS_W-1:0]  DAYS_PER_YEAR    = 16'd365;
    localparam logic [YEAR_W-1:0]  LAST_YEAR        = 7'd99;
    localparam logic [MONTH_W-1:0] MARCH            = 4'd3;

    // days before the given month in a common year; zero adds nothing,
    // anything past december counts as december
    function automatic logic [DBM_W-1:0] days_before_month(input logic [MONTH_W-1:0] m);
        logic [DBM_W-1:0] d;
        unique case (m)
            4'd0:    d = 9'd0;
            4'd1:    d = 9'd0;
            4'd2:    d = 9'd31;
            4'd3:    d = 9'd59;
            4'd4:    d = 9'd90;
            4'd5:    d = 9'd120;
            4'd6:    d = 9'd151;
            4'd7:    d = 9'd181;
            4'd8:    d = 9'd212;
            4'd9:    d = 9'd243;
            4'd10:   d = 9'd273;
            4'd11:   d = 9'd304;
            default: d = 9'd334;
        endcase
        return d;
    endfunction

endpackage

### hw/rtl/cts_day_count.sv
// day index of a reading: whole years, leap days, earlier months and day of month
// depends on cts_pkg
module cts_day_count (
    input  logic [cts_pkg::YEAR_W-1:0]  year,
    input  logic [cts_pkg::MONTH_W-1:0] month,
    input  logic [cts_pkg::DAY_W-1:0]   day_of_month,
    output logic [cts_pkg::DAYS_W-1:0]  days
);
    import cts_pkg::*;

    logic [YEAR_W:0]     leap_sum;
    logic [DAYS_W-1:0]   year_days;
    logic [DAYS_W-1:0]   leap_days;
    logic                leap_extra;

    // leap years before this one: every year index divisible by 4
    assign leap_sum   = {1'b0, year} + (YEAR_W+1)'(3);
    assign leap_days  = DAYS_W'(leap_sum >> 2);
    assign year_days  = DAYS_W'(year) * DAYS_PER_YEAR;
    assign leap_extra = (year[1:0] == 2'b00) && (month >= MARCH);

    assign days = year_days + leap_days + DAYS_W'(days_before_month(month))
                + DAYS_W'(leap_extra) + DAYS_W'(day_of_month);

endmodule

### hw/rtl/calendar_to_seconds.sv
// calendar to seconds converter, top level
// depends on cts_pkg and cts_day_count
//
// usage:
//   s_ channel takes one calendar word (year, month, day of month, hours,
//   minutes, seconds); m_ channel returns one 32-bit seconds count per word,
//   in order, wrapping modulo 2^32
//   a change of year from 99 to 0 between consecutive words advances an
//   8-bit century counter, each century adding 3155692521 seconds
//   path: a word reaches m_valid through the input register, the product
//     register and the result register
//   throughput: one word per cycle, three-stage pipeline, while m_ready keeps up
//   stall: each stage takes a new word while the one ahead can move, so a
//     stalled m_ready fills the pipe to three words before s_ready drops
//   reset: synchronous active-low aresetn empties the pipe and clears the
//     previous year and the century counter
module calendar_to_seconds (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic [cts_pkg::YEAR_W-1:0]   s_year,
    input  logic [cts_pkg::MONTH_W-1:0]  s_month,
    input  logic [cts_pkg::DAY_W-1:0]    s_day_of_month,
    input  logic [cts_pkg::HOUR_W-1:0]   s_hours,
    input  logic [cts_pkg::MIN_W-1:0]    s_minutes,
    input  logic [cts_pkg::SEC_W-1:0]    s_seconds,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic [cts_pkg::COUNT_W-1:0]  m_seconds_count
);
    import cts_pkg::*;

    // century tracking state, updated in word order at the input
    logic [YEAR_W-1:0]  prev_year_reg, prev_year_next;
    logic [CENT_W-1:0]  century_reg, century_next;

    // stage 1: registered reading plus the century it belongs to
    logic               s1_valid_reg, s1_valid_next;
    logic [YEAR_W-1:0]  s1_year_reg;
    logic [MONTH_W-1:0] s1_month_reg;
    logic [DAY_W-1:0]   s1_day_reg;
    logic [HOUR_W-1:0]  s1_hours_reg;
    logic [MIN_W-1:0]   s1_minutes_reg;
    logic [SEC_W-1:0]   s1_seconds_reg;
    logic [CENT_W-1:0]  s1_century_reg;

    // stage 2: the three partial sums in seconds
    logic               s2_valid_reg, s2_valid_next;
    logic [COUNT_W-1:0] s2_cent_secs_reg, s2_cent_secs_next;
    logic [COUNT_W-1:0] s2_day_secs_reg, s2_day_secs_next;
    logic [TOD_W-1:0]   s2_tod_reg, s2_tod_next;

    // result register
    logic               out_valid_reg, out_valid_next;
    logic [COUNT_W-1:0] out_count_reg, out_count_next;

    logic               s_accept;
    logic               s1_ready, s2_ready, out_ready;
    logic               s1_move, s2_move;
    logic [DAYS_W-1:0]  days;

    // each stage frees up when it is empty or the stage ahead takes its word
    assign out_ready = !out_valid_reg || m_ready;
    assign s2_ready  = !s2_valid_reg || out_ready;
    assign s1_ready  = !s1_valid_reg || s2_ready;
    assign s_ready   = s1_ready;
    assign s_accept  = s_valid && s1_ready;
    assign s1_move   = s1_valid_reg && s2_ready;
    assign s2_move   = s2_valid_reg && out_ready;

    // century steps forward only on the exact 99 to 0 rollover
    always_comb begin
        prev_year_next = prev_year_reg;
        century_next   = century_reg;
        if (s_accept) begin
            prev_year_next = s_year;
            if (prev_year_reg == LAST_YEAR && s_year == '0) begin
                century_next = century_reg + CENT_W'(1);
            end
        end
    end

    cts_day_count u_day_count (
        .year         (s1_year_reg),
        .month        (s1_month_reg),
        .day_of_month (s1_day_reg),
        .days         (days)
    );

    // constant products; century and day products truncated to the 32-bit count, time of day kept in 17 bits
    assign s2_cent_secs_next = COUNT_W'(s1_century_reg) * SECS_PER_CENTURY;
    assign s2_day_secs_next  = COUNT_W'(days) * SECS_PER_DAY;
    assign s2_tod_next       = TOD_W'(s1_hours_reg) * SECS_PER_HOUR
                             + TOD_W'(s1_minutes_reg) * SECS_PER_MINUTE
                             + TOD_W'(s1_seconds_reg);

    assign out_count_next = s2_cent_secs_reg + s2_day_secs_reg + COUNT_W'(s2_tod_reg);

    // valid bits: a stage holds while stalled, loads from behind when free
    always_comb begin
        s1_valid_next  = s1_ready ? s_valid : s1_valid_reg;
        s2_valid_next  = s2_ready ? s1_valid_reg : s2_valid_reg;
        out_valid_next = out_ready ? s2_valid_reg : out_valid_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_year_reg <= '0;
            century_reg   <= '0;
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            prev_year_reg <= prev_year_next;
            century_reg   <= century_next;
            s1_valid_reg  <= s1_valid_next;
            s2_valid_reg  <= s2_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers, no reset needed
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            s1_year_reg    <= s_year;
            s1_month_reg   <= s_month;
            s1_day_reg     <= s_day_of_month;
            s1_hours_reg   <= s_hours;
            s1_minutes_reg <= s_minutes;
            s1_seconds_reg <= s_seconds;
            s1_century_reg <= century_next;
        end
        if (s1_move) begin
            s2_cent_secs_reg <= s2_cent_secs_next;
            s2_day_secs_reg  <= s2_day_secs_next;
            s2_tod_reg       <= s2_tod_next;
        end
        if (s2_move) begin
            out_count_reg <= out_count_next;
        end
    end

    assign m_valid         = out_valid_reg;
    assign m_seconds_count = out_count_reg;

endmodule

### hw/rtl/cts_checker.sv
// port-level checks for calendar_to_seconds, bound to the top level
// depends on cts_pkg and calendar_to_seconds_macros.svh
`include "calendar_to_seconds_macros.svh"

module cts_checker (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    input  logic                         s_ready,
    input  logic                         m_valid,
    input  logic                         m_ready,
    input  logic [cts_pkg::COUNT_W-1:0]  m_seconds_count
);

    logic       in_acc, out_acc;
    logic [2:0] inflight_reg, inflight_next;

    assign in_acc  = s_valid && s_ready;
    assign out_acc = m_valid && m_ready;

    // words accepted but not yet delivered
    always_comb begin
        inflight_next = inflight_reg;
        if (in_acc && !out_acc) begin
            inflight_next = inflight_reg + 3'd1;
        end else if (out_acc && !in_acc) begin
            inflight_next = inflight_reg - 3'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            inflight_reg <= '0;
        end else begin
            inflight_reg <= inflight_next;
        end
    end

    `CTS_ASSERT_RST(a_reset_empties, !aresetn |=> !m_valid)
    `CTS_ASSERT(a_result_holds, m_valid && !m_ready |=> m_valid && $stable(m_seconds_count))
    `CTS_ASSERT(a_depth_bound, inflight_reg <= 3'd3)
    `CTS_ASSERT(a_no_invented, m_valid |-> inflight_reg != 3'd0)
    `CTS_ASSERT(a_ready_when_empty, inflight_reg == 3'd0 |-> s_ready)

endmodule

bind calendar_to_seconds cts_checker u_cts_checker (.*);

### tb/sv/tb_calendar_to_seconds.sv
`timescale 1ns / 1ps
// self-checking testbench for the calendar to seconds converter
// needs cts_pkg and the calendar_to_seconds rtl; nothing else
module tb_calendar_to_seconds;

    localparam int CLK_PERIOD    = 10;
    localparam int RESET_CYCLES  = 5;
    // random part stops once both of these are met; the rollover target is
    // enough to carry the 8-bit century counter past its wrap
    localparam int MIN_WORDS     = 500;
    localparam int MIN_ROLLOVERS = 258;
    // no idling on either side once this few words are still pending
    localparam int QUIET_TAIL    = 40;
    // long receiver hold-off, started once this many results are in
    localparam int HOLD_AT       = 150;
    localparam int HOLD_CYCLES   = 80;
    // pipeline is three deep; wait a bit longer for stray results
    localparam int DRAIN_CYCLES  = 12;
    // cycles with no handshake on either side before giving up
    localparam int STALL_LIMIT   = 2000;

    localparam logic [31:0] DAY_SECS     = 32'd86400;
    localparam logic [31:0] HOUR_SECS    = 32'd3600;
    localparam logic [31:0] MINUTE_SECS  = 32'd60;
    localparam logic [31:0] CENTURY_SECS = 32'd3155692521;
    localparam logic [31:0] DAYS_IN_YEAR = 32'd365;
    localparam logic [6:0]  FINAL_YEAR   = 7'd99;

    // one calendar word as the s_ channel carries it
    typedef struct {
        logic [cts_pkg::YEAR_W-1:0]  year;
        logic [cts_pkg::MONTH_W-1:0] month;
        logic [cts_pkg::DAY_W-1:0]   day_of_month;
        logic [cts_pkg::HOUR_W-1:0]  hours;
        logic [cts_pkg::MIN_W-1:0]   minutes;
        logic [cts_pkg::SEC_W-1:0]   seconds;
    } cal_word_t;

    logic                          aclk           = 1'b0;
    logic                          aresetn        = 1'b0;
    logic                          s_valid        = 1'b0;
    logic                          s_ready;
    logic [cts_pkg::YEAR_W-1:0]    s_year         = '0;
    logic [cts_pkg::MONTH_W-1:0]   s_month        = '0;
    logic [cts_pkg::DAY_W-1:0]     s_day_of_month = '0;
    logic [cts_pkg::HOUR_W-1:0]    s_hours        = '0;
    logic [cts_pkg::MIN_W-1:0]     s_minutes      = '0;
    logic [cts_pkg::SEC_W-1:0]     s_seconds      = '0;
    logic                          m_valid;
    logic                          m_ready        = 1'b0;
    logic [cts_pkg::COUNT_W-1:0]   m_seconds_count;

    // words waiting to be offered, and seconds counts waiting to come back
    cal_word_t                     pending_words[$];
    logic [cts_pkg::COUNT_W-1:0]   expected_counts[$];

    // word currently on the s_ ports
    cal_word_t                     driven;

    // predictor state, advanced at each accepted word
    logic [cts_pkg::YEAR_W-1:0]    pred_prev_year = '0;
    logic [cts_pkg::CENT_W-1:0]    pred_century   = '0;

    // generator view of the stream, used only to decide when to stop
    logic [cts_pkg::YEAR_W-1:0]    gen_prev_year  = '0;
    int                            gen_rollovers  = 0;

    int errors          = 0;
    int words_sent      = 0;
    int results_checked = 0;
    int rollovers_seen  = 0;
    int stall_cycles    = 0;

    // pacing state per side
    int  tx_idle_left = 0;
    int  tx_calm_left = 0;
    int  rx_idle_left = 0;
    int  rx_calm_left = 0;
    int  hold_left    = 0;
    logic hold_done   = 1'b0;

    calendar_to_seconds uut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_year          (s_year),
        .s_month         (s_month),
        .s_day_of_month  (s_day_of_month),
        .s_hours         (s_hours),
        .s_minutes       (s_minutes),
        .s_seconds       (s_seconds),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_seconds_count (m_seconds_count)
    );

    always #(CLK_PERIOD / 2) aclk = ~aclk;

    // seconds count for one word given the century count in force for it;
    // every sum is 32 bits wide so it wraps the same way the block does
    function automatic logic [31:0] calendar_seconds(input cal_word_t w,
                                                     input logic [7:0] centuries);
        logic [31:0] yr;
        logic [31:0] mo;
        logic [31:0] days;
        logic [31:0] total;
        yr   = 32'(w.year);
        mo   = 32'(w.month);
        // whole years before this one, a leap day for each year divisible by 4
        days = yr * DAYS_IN_YEAR + (yr + 32'd3) / 32'd4;
        // anything past december counts as december
        if (mo > 32'd12) begin
            mo = 32'd12;
        end
        // month zero adds no month lengths at all
        case (mo)
            32'd2:   days += 32'd31;
            32'd3:   days += 32'd59;
            32'd4:   days += 32'd90;
            32'd5:   days += 32'd120;
            32'd6:   days += 32'd151;
            32'd7:   days += 32'd181;
            32'd8:   days += 32'd212;
            32'd9:   days += 32'd243;
            32'd10:  days += 32'd273;
            32'd11:  days += 32'd304;
            32'd12:  days += 32'd334;
            default: days += 32'd0;
        endcase
        // leap day of the current year once february is behind us
        if (yr[1:0] == 2'b00 && mo >= 32'd3) begin
            days += 32'd1;
        end
        total = 32'(centuries) * CENTURY_SECS
              + days * DAY_SECS
              + 32'(w.seconds)
              + 32'(w.minutes) * MINUTE_SECS
              + 32'(w.hours) * HOUR_SECS
              // day of month counts as a full day, not day minus one
              + 32'(w.day_of_month) * DAY_SECS;
        return total;
    endfunction

    // queue one word and track rollovers as the block will see them
    task automatic add_word(input logic [cts_pkg::YEAR_W-1:0]  y,
                            input logic [cts_pkg::MONTH_W-1:0] mo,
                            input logic [cts_pkg::DAY_W-1:0]   d,
                            input logic [cts_pkg::HOUR_W-1:0]  h,
                            input logic [cts_pkg::MIN_W-1:0]   mi,
                            input logic [cts_pkg::SEC_W-1:0]   s);
        cal_word_t w;
        w.year         = y;
        w.month        = mo;
        w.day_of_month = d;
        w.hours        = h;
        w.minutes      = mi;
        w.seconds      = s;
        if (gen_prev_year == FINAL_YEAR && y == '0) begin
            gen_rollovers++;
        end
        gen_prev_year = y;
        pending_words.push_back(w);
    endtask

    // word with the given year and random content, either in calendar range
    // or anywhere in the field widths
    task automatic add_random(input logic [cts_pkg::YEAR_W-1:0] y, input logic legal);
        if (legal) begin
            add_word(y, 4'($urandom_range(1, 12)), 5'($urandom_range(1, 31)),
                     5'($urandom_range(0, 23)), 6'($urandom_range(0, 59)),
                     6'($urandom_range(0, 59)));
        end else begin
            add_word(y, 4'($urandom), 5'($urandom), 5'($urandom),
                     6'($urandom), 6'($urandom));
        end
    endtask

    // random idle bursts, with calm stretches between;
    // no idling at all in the tail of the run
    task automatic pace(inout int idle_left, inout int calm_left,
                        input logic quiet, output logic go);
        int r;
        go = 1'b1;
        if (quiet) begin
            idle_left = 0;
        end else if (idle_left > 0) begin
            idle_left--;
            go = 1'b0;
        end else if (calm_left > 0) begin
            calm_left--;
        end else begin
            r = $urandom_range(0, 99);
            if (r < 20) begin
                idle_left = $urandom_range(1, 9) - 1;
                go = 1'b0;
            end else if (r < 28) begin
                calm_left = $urandom_range(20, 60);
            end
        end
    endtask

    // sender: offers pending words, holds each until accepted, and feeds the
    // predictor at every accepting edge
    always @(posedge aclk) begin : driver
        logic next_valid;
        logic go;
        cal_word_t nxt;
        if (!aresetn) begin
            s_valid        <= 1'b0;
            pred_prev_year  = '0;
            pred_century    = '0;
        end else begin
            next_valid = s_valid;
            if (s_valid && s_ready) begin
                // century step comes before the count is formed
                if (pred_prev_year == FINAL_YEAR && driven.year == '0) begin
                    pred_century = pred_century + 8'd1;
                    rollovers_seen++;
                end
                pred_prev_year = driven.year;
                expected_counts.push_back(calendar_seconds(driven, pred_century));
                words_sent++;
                next_valid = 1'b0;
            end
            // a new word only once the slot is free; valid never drops early
            if (!next_valid) begin
                pace(tx_idle_left, tx_calm_left, pending_words.size() < QUIET_TAIL, go);
                if (go && pending_words.size() > 0) begin
                    nxt            = pending_words.pop_front();
                    driven         = nxt;
                    s_year         <= nxt.year;
                    s_month        <= nxt.month;
                    s_day_of_month <= nxt.day_of_month;
                    s_hours        <= nxt.hours;
                    s_minutes      <= nxt.minutes;
                    s_seconds      <= nxt.seconds;
                    next_valid     = 1'b1;
                end
            end
            s_valid <= next_valid;
        end
    end

    // receiver: checks each accepted result against the oldest expectation
    always @(posedge aclk) begin : monitor
        logic go;
        logic [cts_pkg::COUNT_W-1:0] want;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (expected_counts.size() == 0) begin
                    $error("seconds_count: result with no word behind it, expected none, actual %0d",
                           m_seconds_count);
                    errors++;
                end else begin
                    want = expected_counts.pop_front();
                    if (m_seconds_count !== want) begin
                        $error("seconds_count mismatch: expected %0d, actual %0d",
                               want, m_seconds_count);
                        errors++;
                    end
                end
                results_checked++;
            end
            // one long hold-off so the pipe fills and s_ready drops
            if (!hold_done && results_checked >= HOLD_AT) begin
                hold_left = HOLD_CYCLES;
                hold_done = 1'b1;
            end
            if (hold_left > 0) begin
                hold_left--;
                go = 1'b0;
            end else begin
                pace(rx_idle_left, rx_calm_left, pending_words.size() < QUIET_TAIL, go);
            end
            m_ready <= go;
        end
    end

    // watchdog: too long with no word moving on either channel
    always @(posedge aclk) begin : watchdog
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            stall_cycles = 0;
        end else begin
            stall_cycles++;
        end
        if (stall_cycles >= STALL_LIMIT) begin
            $display("timeout after %0d idle cycles", stall_cycles);
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial begin : stimulus
        int kind;
        int run_len;
        logic [cts_pkg::YEAR_W-1:0] y;

        // directed words
        // all zero: month zero and day zero
        add_word(7'd0, 4'd0, 5'd0, 5'd0, 6'd0, 6'd0);
        // first second of january in a leap year
        add_word(7'd0, 4'd1, 5'd1, 5'd0, 6'd0, 6'd0);
        // last legal reading of a century
        add_word(7'd99, 4'd12, 5'd31, 5'd23, 6'd59, 6'd59);
        // step from 99 to 0 bumps the century counter, in march of a leap year
        add_word(7'd0, 4'd3, 5'd1, 5'd0, 6'd0, 6'd0);
        // same year again, no step
        add_word(7'd0, 4'd2, 5'd29, 5'd12, 6'd30, 6'd30);
        // every field at its all-ones value
        add_word(7'd127, 4'd15, 5'd31, 5'd31, 6'd63, 6'd63);
        // year past 99 and month 13 clamped to december
        add_word(7'd100, 4'd13, 5'd15, 5'd6, 6'd7, 6'd8);
        // leap year either side of february, then a common year in march
        add_word(7'd4, 4'd2, 5'd28, 5'd1, 6'd2, 6'd3);
        add_word(7'd4, 4'd3, 5'd1, 5'd1, 6'd2, 6'd3);
        add_word(7'd3, 4'd3, 5'd1, 5'd1, 6'd2, 6'd3);
        // 99 to a nonzero year does not step the century
        add_word(7'd99, 4'd6, 5'd10, 5'd10, 6'd10, 6'd10);
        add_word(7'd1, 4'd6, 5'd10, 5'd10, 6'd10, 6'd10);
        // 98 to 0 does not step either
        add_word(7'd98, 4'd11, 5'd30, 5'd20, 6'd40, 6'd50);
        add_word(7'd0, 4'd11, 5'd30, 5'd20, 6'd40, 6'd50);
        // a second real rollover
        add_word(7'd99, 4'd7, 5'd4, 5'd9, 6'd41, 6'd17);
        add_word(7'd0, 4'd7, 5'd4, 5'd9, 6'd41, 6'd17);
        // alternating bit patterns in every field, in both phases
        add_word(7'h55, 4'h5, 5'h15, 5'h15, 6'h15, 6'h15);
        add_word(7'h2a, 4'ha, 5'h0a, 5'h0a, 6'h2a, 6'h2a);

        // random part: mostly 99 to 0 pairs so the century counter wraps in
        // a short run, plus short year runs, noise and broken rollovers
        while (pending_words.size() < MIN_WORDS || gen_rollovers < MIN_ROLLOVERS) begin
            kind = $urandom_range(0, 19);
            case (kind)
                16: begin
                    add_random(7'($urandom_range(0, 127)), 1'b0);
                end
                17: begin
                    // ascending years at the end of a century
                    y       = 7'($urandom_range(95, 99));
                    run_len = $urandom_range(2, 5);
                    repeat (run_len) begin
                        add_random(y, 1'b1);
                        y = (y == FINAL_YEAR) ? 7'd0 : y + 7'd1;
                    end
                end
                18: begin
                    // 99 followed by anything but 0
                    add_random(7'd99, 1'($urandom_range(0, 1)));
                    add_random(7'($urandom_range(1, 127)), 1'b1);
                end
                19: begin
                    add_random(7'd99, 1'b0);
                    add_random(7'd0, 1'b0);
                end
                default: begin
                    add_random(7'd99, 1'b1);
                    add_random(7'd0, 1'b1);
                end
            endcase
        end

        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;

        // all words accepted, then all results back, then a short drain
        do @(negedge aclk); while (pending_words.size() != 0 || s_valid);
        while (expected_counts.size() != 0) @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);

        $display("%0d calendar words checked, %0d century rollovers, final century count %0d",
                 words_sent, rollovers_seen, pred_century);
        $display("directed extremes, clamped months, stray years and one long output stall included");
        if (errors == 0 && expected_counts.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
